// ----- src/sjis_aware_substring_search_defines.svh -----
// assertion macros for the shift-jis substring search block
`ifndef SJIS_AWARE_SUBSTRING_SEARCH_DEFINES_SVH
`define SJIS_AWARE_SUBSTRING_SEARCH_DEFINES_SVH

// combinational check sampled at every rising clock edge
`define SSRCH_ASSERT(name, expr, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (expr)) else $error(msg);

// implication or other temporal property
`define SSRCH_ASSERT_PROP(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

`endif

// ----- src/ssrch_pkg.sv -----
// types, codes and helpers shared by the substring search block
package ssrch_pkg;

  localparam int unsigned MaxPatternDef   = 255;
  localparam int unsigned PositionBitsDef = 32;

  localparam logic [1:0] MODE_CLEAR  = 2'd0;
  localparam logic [1:0] MODE_APPEND = 2'd1;
  localparam logic [1:0] MODE_TEXT   = 2'd2;
  localparam logic [1:0] MODE_END    = 2'd3;

  localparam logic [1:0] STATUS_FOUND     = 2'd0;
  localparam logic [1:0] STATUS_NOT_FOUND = 2'd1;
  localparam logic [1:0] STATUS_TOO_LONG  = 2'd2;

  typedef struct packed {
    logic [1:0] mode;
    logic [7:0] data_byte;
  } in_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] position;
  } out_t;

  typedef struct packed {
    logic text_en;
    logic pat_we;
  } chain_ctrl_t;

  function automatic logic is_lead_range(input logic [7:0] b);
    return ((b >= 8'h81) && (b <= 8'h9f)) || ((b >= 8'he0) && (b <= 8'hfc));
  endfunction

endpackage

// ----- src/ssrch_cell.sv -----
// one cell: a pattern byte and a window byte, each handed on to the next cell
module ssrch_cell
  import ssrch_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  chain_ctrl_t ctrl_i,
  input  logic [7:0]  pat_i,
  input  logic [7:0]  win_i,
  input  logic        trail_i,
  input  logic        used_i,
  input  logic        first_i,
  output logic [7:0]  pat_o,
  output logic [7:0]  win_o,
  output logic        trail_o,
  output logic        ok_o
);

  logic [7:0] pat_q;
  logic [7:0] win_q;
  logic       trail_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q   <= '0;
      trail_q <= 1'b0;
    end else if (ctrl_i.text_en) begin
      win_q   <= win_i;
      trail_q <= trail_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.pat_we) begin
      pat_q <= pat_i;
    end
  end

  // window byte at this place against the pattern byte lined up with it
  assign ok_o    = !used_i || ((win_i == pat_q) && !(first_i && trail_i));
  assign pat_o   = pat_q;
  assign win_o   = win_q;
  assign trail_o = trail_q;

endmodule

// ----- src/ssrch_chain.sv -----
// row of window cells: pattern and text bytes shift along, all places compared at once
module ssrch_chain
  import ssrch_pkg::*;
#(
  parameter int unsigned MAX_PATTERN = MaxPatternDef,
  parameter int unsigned LEN_W       = $clog2(MAX_PATTERN + 1)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  chain_ctrl_t      ctrl_i,
  input  logic [7:0]       data_i,
  input  logic             trail_i,
  input  logic [LEN_W-1:0] len_i,
  output logic             match_o
);

  logic [MAX_PATTERN:0][7:0] pat_link;
  logic [MAX_PATTERN:0][7:0] win_link;
  logic [MAX_PATTERN:0]      trail_link;
  logic [MAX_PATTERN-1:0]    ok;

  assign pat_link[0]   = data_i;
  assign win_link[0]   = data_i;
  assign trail_link[0] = trail_i;

  for (genvar gi = 0; gi < MAX_PATTERN; gi++) begin : g_cell
    ssrch_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctrl_i  (ctrl_i),
      .pat_i   (pat_link[gi]),
      .win_i   (win_link[gi]),
      .trail_i (trail_link[gi]),
      .used_i  (len_i > LEN_W'(gi)),
      .first_i (len_i == LEN_W'(gi + 1)),
      .pat_o   (pat_link[gi+1]),
      .win_o   (win_link[gi+1]),
      .trail_o (trail_link[gi+1]),
      .ok_o    (ok[gi])
    );
  end

  assign match_o = &ok;

endmodule

// ----- src/sjis_aware_substring_search.sv -----
// top level: shift-jis aware streaming substring search
//
//   channel | direction | payload | fields
//   in      | input     | in_t    | mode, data_byte
//   out     | output    | out_t   | status, position
//
// one input transfer per cycle while not stalled; a result sits in the output
// register right after the edge that takes its input transfer, since the cell
// row compares the whole window against the pattern in that same cycle
// reset clears length, flags, byte count and the text window; pattern bytes are
// undefined until appended
// input stalls only while an unread result sits in the output register
module sjis_aware_substring_search
  import ssrch_pkg::*;
#(
  parameter int unsigned MAX_PATTERN   = MaxPatternDef,
  parameter int unsigned POSITION_BITS = PositionBitsDef
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  in_t  in_data_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output out_t out_data_o
);

  `include "sjis_aware_substring_search_defines.svh"

  localparam int unsigned LEN_W = $clog2(MAX_PATTERN + 1);
  localparam logic [LEN_W-1:0] LenMax = LEN_W'(MAX_PATTERN);
  localparam logic [POSITION_BITS-1:0] PosMax = '1;

  logic [LEN_W-1:0]         len_q, len_d;
  logic                     rej_q, rej_d;
  logic [POSITION_BITS-1:0] bytes_q, bytes_d, bytes_inc;
  logic                     prev_lead_q, prev_lead_d;
  logic                     reported_q, reported_d;
  logic                     out_valid_q;
  out_t                     out_q;

  logic                     accept;
  logic                     is_append, is_text, is_end;
  logic                     clr;
  chain_ctrl_t              ctrl;
  logic                     win_match;
  logic                     any_hit;
  logic                     emit;
  out_t                     res;
  logic [POSITION_BITS-1:0] pos;
  logic [POSITION_BITS+31:0] pos_ext;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;
  assign is_append  = accept && (in_data_i.mode == MODE_APPEND);
  assign is_text    = accept && (in_data_i.mode == MODE_TEXT);
  assign is_end     = accept && (in_data_i.mode == MODE_END);

  assign clr          = accept && ((in_data_i.mode == MODE_CLEAR) ||
                                   (in_data_i.mode == MODE_END));
  assign ctrl.text_en = is_text;
  assign ctrl.pat_we  = is_append && !rej_q && (len_q != LenMax);

  ssrch_chain #(
    .MAX_PATTERN(MAX_PATTERN),
    .LEN_W      (LEN_W)
  ) u_chain (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (ctrl),
    .data_i   (in_data_i.data_byte),
    .trail_i  (prev_lead_q),
    .len_i    (len_q),
    .match_o  (win_match)
  );

  assign bytes_inc = (bytes_q == PosMax) ? bytes_q : bytes_q + 1'b1;

  // window only counts once enough text bytes have arrived
  assign any_hit = win_match && (bytes_inc >= POSITION_BITS'(len_q));

  always_comb begin
    if (len_q == '0) begin
      pos = '0;
    end else if (bytes_inc == PosMax) begin
      pos = PosMax;
    end else begin
      pos = bytes_inc - POSITION_BITS'(len_q);
    end
  end

  assign pos_ext = {32'b0, pos};

  always_comb begin
    emit         = 1'b0;
    res.status   = STATUS_FOUND;
    res.position = '0;
    if (is_text && !reported_q && !rej_q && ((len_q == '0) || any_hit)) begin
      emit         = 1'b1;
      res.position = pos_ext[31:0];
    end else if (is_end && !reported_q) begin
      emit = 1'b1;
      if (rej_q) begin
        res.status = STATUS_TOO_LONG;
      end else if (len_q != '0) begin
        res.status = STATUS_NOT_FOUND;
      end
    end
  end

  always_comb begin
    len_d       = len_q;
    rej_d       = rej_q;
    bytes_d     = bytes_q;
    prev_lead_d = prev_lead_q;
    reported_d  = reported_q;
    if (clr) begin
      bytes_d     = '0;
      prev_lead_d = 1'b0;
      reported_d  = 1'b0;
      if (!is_end) begin
        len_d = '0;
        rej_d = 1'b0;
      end
    end else if (is_append) begin
      if (ctrl.pat_we) begin
        len_d = len_q + 1'b1;
      end else begin
        rej_d = 1'b1;
      end
    end else if (is_text) begin
      bytes_d     = bytes_inc;
      prev_lead_d = is_lead_range(in_data_i.data_byte) && !prev_lead_q;
      reported_d  = reported_q || emit;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q       <= '0;
      rej_q       <= 1'b0;
      bytes_q     <= '0;
      prev_lead_q <= 1'b0;
      reported_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      len_q       <= len_d;
      rej_q       <= rej_d;
      bytes_q     <= bytes_d;
      prev_lead_q <= prev_lead_d;
      reported_q  <= reported_d;
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `SSRCH_ASSERT(a_len_bound, len_q <= LenMax, "pattern length beyond maximum")
  `SSRCH_ASSERT(a_rej_full, !rej_q || (len_q == LenMax), "rejected with room left")
  `SSRCH_ASSERT_PROP(a_reported_sticky, (reported_q && !clr) |=> reported_q, "report lost")
  `SSRCH_ASSERT_PROP(a_clr_text, clr |=> ((bytes_q == '0) && !prev_lead_q), "text not cleared")

endmodule

// ----- tb/sjis_aware_substring_search_test.sv -----
// testbench for the shift-jis aware substring search: random and directed streams
module sjis_aware_substring_search_test
  import ssrch_pkg::*;
();

  class match_scoreboard;
    logic [7:0]                 pat_bytes [MaxPatternDef];
    int unsigned                pat_len;
    bit                         rejected;
    logic [7:0]                 win_bytes [MaxPatternDef];
    bit                         win_trail [MaxPatternDef];
    int unsigned                win_next;
    logic [PositionBitsDef-1:0] text_count;
    bit                         prev_lead;
    bit                         reported;
    out_t                       expected_q [$];
    int unsigned                mismatches;
    int unsigned                found_count;
    int unsigned                not_found_count;
    int unsigned                too_long_count;

    function new();
      foreach (pat_bytes[i]) pat_bytes[i] = '0;
      pat_len    = 0;
      rejected   = 1'b0;
      mismatches = 0;
      clear_text();
    endfunction

    function void clear_text();
      foreach (win_bytes[i]) begin
        win_bytes[i] = '0;
        win_trail[i] = 1'b0;
      end
      win_next   = 0;
      text_count = '0;
      prev_lead  = 1'b0;
      reported   = 1'b0;
    endfunction

    function void push_result(logic [1:0] status, logic [31:0] position);
      out_t res;
      res.status   = status;
      res.position = position;
      expected_q.push_back(res);
      reported = 1'b1;
    endfunction

    function bit window_hit();
      int unsigned base;
      base = (win_next + MaxPatternDef - pat_len) % MaxPatternDef;
      if (win_trail[base]) return 1'b0;
      for (int unsigned j = 0; j < pat_len; j++) begin
        if (win_bytes[(base + j) % MaxPatternDef] != pat_bytes[j]) return 1'b0;
      end
      return 1'b1;
    endfunction

    // notes one accepted input transfer and predicts what it causes
    function void note_input(in_t item);
      bit   trail;
      logic [7:0] b;
      b = item.data_byte;
      case (item.mode)
        MODE_CLEAR: begin
          pat_len  = 0;
          rejected = 1'b0;
          clear_text();
        end
        MODE_APPEND: begin
          if (!rejected) begin
            if (pat_len >= MaxPatternDef) begin
              rejected = 1'b1;
            end else begin
              pat_bytes[pat_len] = b;
              pat_len++;
            end
          end
        end
        MODE_TEXT: begin
          trail     = prev_lead;
          prev_lead = !prev_lead && (b inside {[8'h81:8'h9f], [8'he0:8'hfc]});
          win_bytes[win_next] = b;
          win_trail[win_next] = trail;
          win_next = (win_next + 1) % MaxPatternDef;
          if (text_count != '1) text_count++;
          if (!reported && !rejected) begin
            if (pat_len == 0) begin
              push_result(STATUS_FOUND, '0);
            end else if (text_count >= pat_len && window_hit()) begin
              push_result(STATUS_FOUND, (text_count == '1) ? text_count : text_count - pat_len);
            end
          end
        end
        default: begin
          if (!reported) begin
            if (rejected) push_result(STATUS_TOO_LONG, '0);
            else if (pat_len == 0) push_result(STATUS_FOUND, '0);
            else push_result(STATUS_NOT_FOUND, '0);
          end
          clear_text();
        end
      endcase
    endfunction

    function void check_result(out_t got);
      out_t want;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("unexpected result: status %0d position %0d", got.status, got.position);
        end
        return;
      end
      want = expected_q.pop_front();
      case (got.status)
        STATUS_FOUND:     found_count++;
        STATUS_NOT_FOUND: not_found_count++;
        default:          too_long_count++;
      endcase
      if (got.status !== want.status || got.position !== want.position) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("result mismatch: expected status %0d position %0d, got status %0d position %0d",
                   want.status, want.position, got.status, got.position);
        end
      end
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction
  endclass

  logic clk_i;
  logic rst_ni      = 1'b0;
  logic in_valid_i  = 1'b0;
  logic in_ready_o;
  in_t  in_data_i   = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  out_t out_data_o;

  match_scoreboard sb = new();
  int unsigned     items_sent = 0;
  logic [7:0]      probe_bytes [10] = '{8'h41, 8'h42, 8'h81, 8'h9f, 8'he0,
                                        8'hfc, 8'h80, 8'ha0, 8'hfd, 8'h00};

  sjis_aware_substring_search i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #20_000_000;
    $display("tb: failure");
    $finish;
  end

  // idle phases: none, sender idle, receiver stalling, both lightly
  function automatic int unsigned idle_pct(bit receiver);
    case ((items_sent / 150) % 4)
      0:       return 0;
      1:       return receiver ? 0 : 84;
      2:       return receiver ? 84 : 0;
      default: return 11;
    endcase
  endfunction

  function automatic logic [7:0] pick_byte();
    if ($urandom_range(4) == 0) return 8'($urandom_range(255));
    return probe_bytes[$urandom_range(9)];
  endfunction

  task automatic send_item(input logic [1:0] mode, input logic [7:0] data);
    in_t item;
    item.mode      = mode;
    item.data_byte = data;
    while ($urandom_range(99) < idle_pct(1'b0)) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= item;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    sb.note_input(item);
    items_sent++;
  endtask

  initial begin : receiver
    int unsigned hold_left;
    bit          hold_done;
    hold_left = 0;
    hold_done = 1'b0;
    forever begin
      @(posedge clk_i);
      if (out_valid_o && out_ready_i) sb.check_result(out_data_o);
      if (!hold_done && items_sent >= 800) begin
        hold_done = 1'b1;
        hold_left = 400;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= ($urandom_range(99) >= idle_pct(1'b1));
      end
    end
  end

  initial begin : stimulus
    logic [7:0]  long_pat [MaxPatternDef];
    logic [7:0]  seq_pat [8];
    int unsigned pat_n;
    int unsigned text_n;
    int unsigned cut;

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty pattern, empty text and first text byte
    send_item(MODE_END, 8'h00);
    send_item(MODE_TEXT, 8'h41);
    send_item(MODE_TEXT, 8'hff);
    send_item(MODE_END, 8'hff);
    // double-byte pattern, first hit starts on a trail byte
    send_item(MODE_APPEND, 8'h82);
    send_item(MODE_APPEND, 8'ha0);
    send_item(MODE_TEXT, 8'h81);
    send_item(MODE_TEXT, 8'h82);
    send_item(MODE_TEXT, 8'ha0);
    send_item(MODE_TEXT, 8'h82);
    send_item(MODE_TEXT, 8'ha0);
    send_item(MODE_TEXT, 8'h00);
    send_item(MODE_END, 8'h00);
    // not found
    send_item(MODE_TEXT, 8'h41);
    send_item(MODE_END, 8'h00);
    // clear, then empty search again
    send_item(MODE_CLEAR, 8'hff);
    send_item(MODE_END, 8'haa);
    // trail-byte skip at the top lead byte
    send_item(MODE_APPEND, 8'h00);
    send_item(MODE_TEXT, 8'hfc);
    send_item(MODE_TEXT, 8'h00);
    send_item(MODE_TEXT, 8'h00);
    send_item(MODE_END, 8'h00);
    // pattern grows while text streams
    send_item(MODE_TEXT, 8'h00);
    send_item(MODE_APPEND, 8'h41);
    send_item(MODE_TEXT, 8'h41);
    send_item(MODE_END, 8'h00);

    // longest pattern, then two bytes too many
    send_item(MODE_CLEAR, 8'h00);
    for (int i = 0; i < MaxPatternDef; i++) begin
      long_pat[i] = 8'($urandom_range(255));
      send_item(MODE_APPEND, long_pat[i]);
    end
    repeat (3) send_item(MODE_TEXT, 8'h41);
    for (int i = 0; i < MaxPatternDef; i++) send_item(MODE_TEXT, long_pat[i]);
    send_item(MODE_END, 8'h00);
    send_item(MODE_APPEND, 8'h5a);
    send_item(MODE_APPEND, 8'ha5);
    for (int i = 0; i < 3; i++) send_item(MODE_TEXT, long_pat[i]);
    send_item(MODE_END, 8'h00);
    send_item(MODE_END, 8'h00);
    send_item(MODE_CLEAR, 8'h00);

    while (items_sent < 1100) begin
      if ($urandom_range(7) == 0) begin
        repeat ($urandom_range(8, 1)) begin
          send_item(2'($urandom_range(3)), 8'($urandom_range(255)));
        end
      end else begin
        if ($urandom_range(9) != 0) send_item(MODE_CLEAR, 8'($urandom_range(255)));
        pat_n = $urandom_range(5);
        for (int i = 0; i < pat_n; i++) begin
          seq_pat[i] = pick_byte();
          send_item(MODE_APPEND, seq_pat[i]);
        end
        text_n = $urandom_range(24);
        cut    = $urandom_range(text_n);
        for (int i = 0; i <= text_n; i++) begin
          if (i == cut && $urandom_range(1) == 1) begin
            for (int k = 0; k < pat_n; k++) send_item(MODE_TEXT, seq_pat[k]);
          end
          if ($urandom_range(19) == 0) send_item(MODE_APPEND, pick_byte());
          if (i < text_n) send_item(MODE_TEXT, pick_byte());
        end
        if ($urandom_range(19) != 0) send_item(MODE_END, 8'($urandom_range(255)));
      end
    end
    in_valid_i <= 1'b0;

    while (sb.pending() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);

    $display("sent %0d input transfers across all idle phases and one long output hold",
             items_sent);
    $display("checked results: %0d found, %0d not found, %0d pattern too long, %0d mismatches",
             sb.found_count, sb.not_found_count, sb.too_long_count, sb.mismatches);
    if (sb.mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
